/* src/mesi_pkg.sv */
// ----------------------------------------------------------------------------
// MESI transition package
// Shared types and codes for the MESI line-state decision pipeline.
// ----------------------------------------------------------------------------
package mesi_pkg;

  localparam int TAG_W        = 48;  // width of the victim and message tag fields
  localparam int TAG_BITS_DEF = 48;  // default number of meaningful tag bits

  typedef enum logic [2:0] {
    CMD_LOCAL_HIT  = 3'd0,
    CMD_LOCAL_MISS = 3'd1,
    CMD_SNOOP_HIT  = 3'd2,
    CMD_SNOOP_MISS = 3'd3,
    CMD_FLUSH      = 3'd4,
    CMD_INSERT     = 3'd5,
    CMD_FILL       = 3'd6,
    CMD_UNUSED     = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_UPDATE = 2'd2,
    OP_EVICT  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_I = 2'd0,
    ST_E = 2'd1,
    ST_S = 2'd2,
    ST_M = 2'd3
  } mstate_t;

  typedef enum logic [2:0] {
    RT_NONE   = 3'd0,
    RT_REPLY  = 3'd1,
    RT_LOWER  = 3'd2,
    RT_MISS   = 3'd3,
    RT_RETIRE = 3'd4
  } route_t;

  typedef enum logic [0:0] {
    REG_PRIVATE_LEVEL      = 1'b0,
    REG_LAST_PRIVATE_LEVEL = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic private_level;
    logic last_private_level;
  } cfg_t;

  typedef struct packed {
    cmd_t             cmd;
    op_t              op_type;
    mstate_t          line_state;
    logic             shared_in;
    mstate_t          arg_state;
    logic [TAG_W-1:0] victim_tag;
  } req_t;

  typedef struct packed {
    mstate_t          new_state;
    logic             state_write;
    route_t           route;
    logic             evict_to_lower;
    logic             evict_to_upper;
    logic             update_to_upper;
    logic             update_to_lower;
    logic             shared_out;
    logic             data_out;
    logic [TAG_W-1:0] message_tag;
    logic             error;
  } rsp_t;

endpackage

/* src/mesi_in_stage.sv */
// ----------------------------------------------------------------------------
// MESI input stage
// Registers one request beat; holds it while the next stage is blocked.
// ----------------------------------------------------------------------------
module mesi_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  mesi_pkg::req_t req_data,
  output logic          hold_valid,
  output mesi_pkg::req_t hold_data,
  input  logic          dn_ready
);
  import mesi_pkg::*;

  logic load;

  // Take a new beat whenever the register is empty or drains this cycle.
  assign load      = !hold_valid || dn_ready;
  assign req_stall = !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (load) begin
      hold_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && req_valid) begin
      hold_data <= req_data;
    end
  end

endmodule

/* src/mesi_decide.sv */
// ----------------------------------------------------------------------------
// MESI decision logic
// Works out next state, routing, messages and snoop flags for one request.
// ----------------------------------------------------------------------------
module mesi_decide #(
  parameter int TAG_BITS = mesi_pkg::TAG_BITS_DEF
) (
  input  mesi_pkg::cfg_t cfg,
  input  mesi_pkg::req_t req,
  output mesi_pkg::rsp_t rsp
);
  import mesi_pkg::*;

  localparam int KeepBits = (TAG_BITS >= TAG_W) ? TAG_W : TAG_BITS;
  localparam logic [TAG_W-1:0] TagMask = {TAG_W{1'b1}} >> (TAG_W - KeepBits);

  logic low;
  assign low = cfg.last_private_level;

  always_comb begin
    rsp                 = '0;
    rsp.new_state       = req.line_state;
    rsp.route           = RT_NONE;
    unique case (req.cmd)
      CMD_LOCAL_HIT: begin
        if (req.op_type == OP_EVICT) begin
          rsp.new_state   = ST_I;
          rsp.state_write = 1'b1;
          rsp.route       = RT_RETIRE;
        end else if (req.op_type == OP_UPDATE && req.line_state != ST_M) begin
          rsp.route = RT_LOWER;
        end else if (req.line_state == ST_I) begin
          rsp.route = RT_MISS;
        end else if (req.line_state == ST_M) begin
          rsp.route = RT_REPLY;
        end else if (req.op_type == OP_WRITE) begin
          rsp.state_write = 1'b1;
          if (low) begin
            rsp.new_state      = ST_M;
            rsp.route          = RT_REPLY;
            rsp.evict_to_lower = (req.line_state == ST_S);
          end else begin
            rsp.new_state = ST_I;
            rsp.route     = RT_MISS;
          end
        end else begin
          rsp.route = RT_REPLY;
        end
      end
      CMD_LOCAL_MISS: begin
        rsp.route = RT_LOWER;
      end
      CMD_SNOOP_HIT: begin
        if (req.op_type == OP_EVICT) begin
          rsp.evict_to_upper = low;
          rsp.new_state      = ST_I;
          rsp.state_write    = 1'b1;
          rsp.route          = RT_RETIRE;
        end else if (req.op_type == OP_UPDATE && !low) begin
          rsp.new_state   = req.arg_state;
          rsp.state_write = 1'b1;
          rsp.route       = RT_RETIRE;
        end else begin
          rsp.route = RT_REPLY;
          if (req.line_state != ST_I) begin
            rsp.data_out        = 1'b1;
            rsp.update_to_lower = (req.line_state == ST_M);
            case (req.op_type)
              OP_READ: begin
                rsp.shared_out      = 1'b1;
                rsp.state_write     = (req.line_state != ST_S);
                rsp.new_state       = ST_S;
                rsp.update_to_upper = (req.line_state == ST_E);
              end
              OP_WRITE: begin
                rsp.evict_to_upper = low;
                rsp.new_state      = ST_I;
                rsp.state_write    = 1'b1;
              end
              default: begin
                rsp.new_state   = req.arg_state;
                rsp.state_write = 1'b1;
              end
            endcase
          end
        end
      end
      CMD_SNOOP_MISS: begin
        rsp.route = (req.op_type == OP_EVICT || req.op_type == OP_UPDATE) ?
                    RT_RETIRE : RT_LOWER;
      end
      CMD_FLUSH: begin
        rsp.update_to_lower = (req.line_state == ST_M) && low;
      end
      CMD_INSERT: begin
        rsp.update_to_lower = (req.line_state == ST_M);
        rsp.evict_to_upper  = (req.line_state != ST_I) && low;
        if ((req.line_state == ST_M) || ((req.line_state != ST_I) && low)) begin
          rsp.message_tag = req.victim_tag & TagMask;
        end
        rsp.new_state   = ST_I;
        rsp.state_write = 1'b1;
      end
      CMD_FILL: begin
        if (!low) begin
          rsp.state_write = 1'b1;
          if (req.op_type == OP_EVICT) begin
            rsp.new_state = ST_I;
          end else if (cfg.private_level) begin
            rsp.new_state = req.arg_state;
          end else begin
            rsp.new_state = ST_E;
          end
        end else begin
          case (req.op_type)
            OP_EVICT: begin
              rsp.evict_to_upper = 1'b1;
              rsp.new_state      = ST_I;
              rsp.state_write    = 1'b1;
            end
            OP_UPDATE: begin
              rsp.error = 1'b1;
            end
            OP_READ: begin
              rsp.state_write = 1'b1;
              if (req.shared_in || req.line_state == ST_S) begin
                rsp.new_state = ST_S;
              end else if (req.line_state == ST_M) begin
                rsp.new_state = ST_M;
              end else begin
                rsp.new_state = ST_E;
              end
            end
            default: begin
              if (!req.shared_in) begin
                rsp.new_state   = ST_M;
                rsp.state_write = 1'b1;
              end else if (req.line_state == ST_E) begin
                rsp.evict_to_upper = 1'b1;
                rsp.new_state      = ST_I;
                rsp.state_write    = 1'b1;
              end else begin
                // write to a fill that came back shared
                rsp.error = 1'b1;
              end
            end
          endcase
        end
      end
      default: begin
        rsp.error = 1'b1;
      end
    endcase
  end

endmodule

/* src/mesi_out_stage.sv */
// ----------------------------------------------------------------------------
// MESI result stage
// Registers one decided response beat and holds it while the sink stalls.
// ----------------------------------------------------------------------------
module mesi_out_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  output logic          up_ready,
  input  mesi_pkg::rsp_t up_data,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output mesi_pkg::rsp_t rsp_data
);
  import mesi_pkg::*;

  assign up_ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (up_ready) begin
      rsp_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      rsp_data <= up_data;
    end
  end

endmodule

/* src/mesi_coherence_transition_logic.sv */
// ----------------------------------------------------------------------------
// MESI coherence transition logic
// Per-line MESI decision pipeline for one cache level.
// ----------------------------------------------------------------------------
// Each request beat carries an event on one cache line (local hit or miss,
// snoop hit or miss, victim flush, insert, fill complete) together with the
// request type, the current line state, the shared flag of the fill, a state
// argument and the victim tag. One response beat comes back per request: the
// next line state and its write enable, a routing decision, evict and update
// messages for the upper and lower levels, the snoop response flags, the
// masked victim tag on inserts that send a message, and an error flag for
// combinations the protocol forbids. The block has two register stages: the
// request is captured in an input register, decided by a small table of
// logic, and captured in the response register. The response beat is valid
// once the request has passed the input register and then the response
// register; throughput is one beat per cycle while the response side does
// not stall, set by the single pass through the decision logic. A stalled
// response holds and backs up into the request side only when both registers
// are full. Write the two configuration registers (index 0 private_level,
// index 1 last_private_level) only while no beat is in flight; cfg_ready is
// always high. TAG_BITS selects how many low bits of the victim tag are kept.
// ----------------------------------------------------------------------------
module mesi_coherence_transition_logic #(
  parameter int TAG_BITS = mesi_pkg::TAG_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic                       cfg_data,
  // request channel
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic [2:0]                 cmd,
  input  logic [1:0]                 op_type,
  input  logic [1:0]                 line_state,
  input  logic                       shared_in,
  input  logic [1:0]                 arg_state,
  input  logic [mesi_pkg::TAG_W-1:0] victim_tag,
  // response channel
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output logic [1:0]                 new_state,
  output logic                       state_write,
  output logic [2:0]                 route,
  output logic                       evict_to_lower,
  output logic                       evict_to_upper,
  output logic                       update_to_upper,
  output logic                       update_to_lower,
  output logic                       shared_out,
  output logic                       data_out,
  output logic [mesi_pkg::TAG_W-1:0] message_tag,
  output logic                       error
);
  import mesi_pkg::*;

  cfg_t cfg;
  req_t req_in;
  req_t hold_req;
  logic hold_valid;
  logic dec_ready;
  rsp_t dec_rsp;
  rsp_t rsp_q;

  // Configuration: always ready, one register per index.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PRIVATE_LEVEL:      cfg.private_level      <= cfg_data;
        REG_LAST_PRIVATE_LEVEL: cfg.last_private_level <= cfg_data;
        default:                cfg                    <= cfg;
      endcase
    end
  end

  // Pack the request fields; the enum casts keep every code, including unused ones.
  assign req_in.cmd        = cmd_t'(cmd);
  assign req_in.op_type    = op_t'(op_type);
  assign req_in.line_state = mstate_t'(line_state);
  assign req_in.shared_in  = shared_in;
  assign req_in.arg_state  = mstate_t'(arg_state);
  assign req_in.victim_tag = victim_tag;

  // Capture the request beat.
  mesi_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_data   (req_in),
    .hold_valid (hold_valid),
    .hold_data  (hold_req),
    .dn_ready   (dec_ready)
  );

  // Decide from the held request and the current configuration.
  mesi_decide #(
    .TAG_BITS (TAG_BITS)
  ) u_decide (
    .cfg (cfg),
    .req (hold_req),
    .rsp (dec_rsp)
  );

  // Register the response beat; advance when the sink takes it.
  mesi_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (hold_valid),
    .up_ready  (dec_ready),
    .up_data   (dec_rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_q)
  );

  assign new_state       = rsp_q.new_state;
  assign state_write     = rsp_q.state_write;
  assign route           = rsp_q.route;
  assign evict_to_lower  = rsp_q.evict_to_lower;
  assign evict_to_upper  = rsp_q.evict_to_upper;
  assign update_to_upper = rsp_q.update_to_upper;
  assign update_to_lower = rsp_q.update_to_lower;
  assign shared_out      = rsp_q.shared_out;
  assign data_out        = rsp_q.data_out;
  assign message_tag     = rsp_q.message_tag;
  assign error           = rsp_q.error;

endmodule

/* src/mesi_checker.sv */
// ----------------------------------------------------------------------------
// MESI transition checker
// Port-level checks on the response beats of the MESI decision pipeline.
// ----------------------------------------------------------------------------
module mesi_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       rsp_valid,
  input logic                       rsp_stall,
  input logic [1:0]                 new_state,
  input logic                       state_write,
  input logic [2:0]                 route,
  input logic                       evict_to_lower,
  input logic                       evict_to_upper,
  input logic                       update_to_upper,
  input logic                       update_to_lower,
  input logic                       shared_out,
  input logic                       data_out,
  input logic [mesi_pkg::TAG_W-1:0] message_tag,
  input logic                       error
);
  import mesi_pkg::*;

  // A stalled response beat holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(new_state) && $stable(route)
      && $stable(state_write) && $stable(message_tag) && $stable(error))
    else $error("response changed while stalled");

  // A forbidden combination writes nothing and sends nothing.
  a_err_quiet: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && error |-> !state_write && route == RT_NONE && !evict_to_lower
      && !evict_to_upper && !update_to_upper && !update_to_lower
      && !shared_out && !data_out && message_tag == '0)
    else $error("error beat carries side effects");

  // Snoop response flags only ride on a reply.
  a_snoop_reply: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (shared_out || data_out) |-> route == RT_REPLY && !error)
    else $error("snoop flags without reply route");

  // An upgrade from shared leaves the line modified.
  a_upgrade: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && evict_to_lower |-> state_write && new_state == ST_M)
    else $error("evict to lower without write to modified");

  // A victim tag goes out only when the line is invalidated on insert.
  a_tag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && message_tag != '0 |-> state_write && new_state == ST_I
      && (update_to_lower || evict_to_upper))
    else $error("message tag without insert message");

endmodule

bind mesi_coherence_transition_logic mesi_checker u_mesi_checker (.*);

/* dv/mesi_coherence_transition_logic_tb.sv */
// ----------------------------------------------------------------------------
// MESI coherence transition logic testbench
// Drives request beats with random gaps, stalls the response side at random,
// predicts every response from the line event and the configuration, and
// compares each response beat field by field, in order.
// ----------------------------------------------------------------------------
module mesi_coherence_transition_logic_tb;
  import mesi_pkg::*;

  localparam int TAG_BITS = TAG_BITS_DEF;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int RANDOM_PHASES = 5;

  // --------------------------------------------------------------------------
  // Scoreboard: holds the expected decisions in arrival order and the copy of
  // the two configuration bits that the decisions depend on.
  // --------------------------------------------------------------------------
  class transition_scoreboard;
    rsp_t             pending_decisions[$];
    logic             private_level;
    logic             last_private_level;
    logic [TAG_W-1:0] tag_mask;
    int unsigned      errors;
    int unsigned      checked;

    function new(int tag_bits);
      logic [63:0] m;
      m = (tag_bits >= 64) ? '1 : ((64'd1 << tag_bits) - 64'd1);
      tag_mask = m[TAG_W-1:0];
      private_level = 1'b0;
      last_private_level = 1'b0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_register(reg_idx_t idx, logic value);
      if (idx == REG_PRIVATE_LEVEL) private_level = value;
      else last_private_level = value;
    endfunction

    // Work out the next line state, route, messages and flags for one event.
    function rsp_t decide_transition(req_t r);
      rsp_t d;
      logic low;
      low = last_private_level;
      d = '0;
      d.new_state = r.line_state;
      d.route = RT_NONE;
      case (r.cmd)
        CMD_LOCAL_HIT: begin
          if (r.op_type == OP_EVICT) begin
            d.new_state = ST_I;
            d.state_write = 1'b1;
            d.route = RT_RETIRE;
          end else if (r.op_type == OP_UPDATE && r.line_state != ST_M) begin
            d.route = RT_LOWER;
          end else if (r.line_state == ST_I) begin
            d.route = RT_MISS;
          end else if (r.line_state == ST_M) begin
            d.route = RT_REPLY;
          end else if (r.op_type == OP_WRITE) begin
            d.state_write = 1'b1;
            if (low) begin
              d.new_state = ST_M;
              d.route = RT_REPLY;
              d.evict_to_lower = (r.line_state == ST_S);
            end else begin
              d.new_state = ST_I;
              d.route = RT_MISS;
            end
          end else begin
            d.route = RT_REPLY;
          end
        end
        CMD_LOCAL_MISS: d.route = RT_LOWER;
        CMD_SNOOP_HIT: begin
          if (r.op_type == OP_EVICT) begin
            d.evict_to_upper = low;
            d.new_state = ST_I;
            d.state_write = 1'b1;
            d.route = RT_RETIRE;
          end else if (r.op_type == OP_UPDATE && !low) begin
            d.new_state = r.arg_state;
            d.state_write = 1'b1;
            d.route = RT_RETIRE;
          end else begin
            d.route = RT_REPLY;
            if (r.line_state != ST_I) begin
              d.data_out = 1'b1;
              d.update_to_lower = (r.line_state == ST_M);
              case (r.op_type)
                OP_READ: begin
                  d.shared_out = 1'b1;
                  if (r.line_state != ST_S) begin
                    d.new_state = ST_S;
                    d.state_write = 1'b1;
                  end
                  d.update_to_upper = (r.line_state == ST_E);
                end
                OP_WRITE: begin
                  d.evict_to_upper = low;
                  d.new_state = ST_I;
                  d.state_write = 1'b1;
                end
                default: begin
                  d.new_state = r.arg_state;
                  d.state_write = 1'b1;
                end
              endcase
            end
          end
        end
        CMD_SNOOP_MISS: begin
          d.route = (r.op_type == OP_EVICT || r.op_type == OP_UPDATE) ? RT_RETIRE : RT_LOWER;
        end
        CMD_FLUSH: d.update_to_lower = (r.line_state == ST_M) && low;
        CMD_INSERT: begin
          d.update_to_lower = (r.line_state == ST_M);
          d.evict_to_upper = (r.line_state != ST_I) && low;
          if (d.update_to_lower || d.evict_to_upper) d.message_tag = r.victim_tag & tag_mask;
          d.new_state = ST_I;
          d.state_write = 1'b1;
        end
        CMD_FILL: begin
          if (!low) begin
            d.state_write = 1'b1;
            if (r.op_type == OP_EVICT) d.new_state = ST_I;
            else if (private_level) d.new_state = r.arg_state;
            else d.new_state = ST_E;
          end else if (r.op_type == OP_EVICT) begin
            d.evict_to_upper = 1'b1;
            d.new_state = ST_I;
            d.state_write = 1'b1;
          end else if (r.op_type == OP_UPDATE) begin
            d.error = 1'b1;
          end else if (r.op_type == OP_READ) begin
            d.state_write = 1'b1;
            if (r.shared_in) d.new_state = ST_S;
            else if (r.line_state == ST_I || r.line_state == ST_E) d.new_state = ST_E;
            else d.new_state = r.line_state;
          end else if (!r.shared_in) begin
            d.new_state = ST_M;
            d.state_write = 1'b1;
          end else if (r.line_state == ST_E) begin
            d.evict_to_upper = 1'b1;
            d.new_state = ST_I;
            d.state_write = 1'b1;
          end else begin
            d.error = 1'b1;
          end
        end
        default: d.error = 1'b1;
      endcase
      return d;
    endfunction

    function void note_request(req_t r);
      pending_decisions.push_back(decide_transition(r));
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("beat %0d: %s expected 0x%0h, got 0x%0h", checked, name, want, got);
        errors++;
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (pending_decisions.size() == 0) begin
        $error("response beat with no request waiting");
        errors++;
        return;
      end
      want = pending_decisions.pop_front();
      compare_field("new_state", 64'(want.new_state), 64'(got.new_state));
      compare_field("state_write", 64'(want.state_write), 64'(got.state_write));
      compare_field("route", 64'(want.route), 64'(got.route));
      compare_field("evict_to_lower", 64'(want.evict_to_lower), 64'(got.evict_to_lower));
      compare_field("evict_to_upper", 64'(want.evict_to_upper), 64'(got.evict_to_upper));
      compare_field("update_to_upper", 64'(want.update_to_upper),
                    64'(got.update_to_upper));
      compare_field("update_to_lower", 64'(want.update_to_lower),
                    64'(got.update_to_lower));
      compare_field("shared_out", 64'(want.shared_out), 64'(got.shared_out));
      compare_field("data_out", 64'(want.data_out), 64'(got.data_out));
      compare_field("message_tag", 64'(want.message_tag), 64'(got.message_tag));
      compare_field("error", 64'(want.error), 64'(got.error));
      checked++;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic             cfg_index = 1'b0;
  logic             cfg_data = 1'b0;
  logic             req_valid = 1'b0;
  logic             req_stall;
  logic [2:0]       cmd = '0;
  logic [1:0]       op_type = '0;
  logic [1:0]       line_state = '0;
  logic             shared_in = 1'b0;
  logic [1:0]       arg_state = '0;
  logic [TAG_W-1:0] victim_tag = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  logic [1:0]       new_state;
  logic             state_write;
  logic [2:0]       route;
  logic             evict_to_lower;
  logic             evict_to_upper;
  logic             update_to_upper;
  logic             update_to_lower;
  logic             shared_out;
  logic             data_out;
  logic [TAG_W-1:0] message_tag;
  logic             error;

  // Zero-gap stretches for both sides when set.
  bit steady = 1'b0;
  int unsigned settings_seen = 0;

  transition_scoreboard sb = new(TAG_BITS);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mesi_coherence_transition_logic #(
    .TAG_BITS(TAG_BITS)
  ) DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .cmd             (cmd),
    .op_type         (op_type),
    .line_state      (line_state),
    .shared_in       (shared_in),
    .arg_state       (arg_state),
    .victim_tag      (victim_tag),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .new_state       (new_state),
    .state_write     (state_write),
    .route           (route),
    .evict_to_lower  (evict_to_lower),
    .evict_to_upper  (evict_to_upper),
    .update_to_upper (update_to_upper),
    .update_to_lower (update_to_lower),
    .shared_out      (shared_out),
    .data_out        (data_out),
    .message_tag     (message_tag),
    .error           (error)
  );

  // One definition of a beat per channel, shared by drivers and monitor so
  // both always agree on which edge moved a beat. Unknown handshake outputs
  // never count as a beat.
  wire cfg_beat = cfg_valid && (cfg_ready === 1'b1);
  wire req_beat = req_valid && (req_stall === 1'b0);
  wire rsp_beat = (rsp_valid === 1'b1) && !rsp_stall;

  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic req_t pack_request(cmd_t c, op_t o, mstate_t s, logic sh, mstate_t a,
                                        logic [TAG_W-1:0] t);
    req_t r;
    r.cmd = c;
    r.op_type = o;
    r.line_state = s;
    r.shared_in = sh;
    r.arg_state = a;
    r.victim_tag = t;
    return r;
  endfunction

  // Write both registers back to back; hold valid high across the two beats
  // and drop it only after the second one is taken.
  task automatic apply_setting(logic pl, logic lpl);
    cfg_valid <= 1'b1;
    cfg_index <= REG_PRIVATE_LEVEL;
    cfg_data  <= pl;
    do @(posedge clk); while (!cfg_beat);
    sb.set_register(REG_PRIVATE_LEVEL, pl);
    cfg_index <= REG_LAST_PRIVATE_LEVEL;
    cfg_data  <= lpl;
    do @(posedge clk); while (!cfg_beat);
    sb.set_register(REG_LAST_PRIVATE_LEVEL, lpl);
    cfg_valid <= 1'b0;
    settings_seen++;
  endtask

  // Idle for a random gap, then present one request beat and hold it until
  // the block takes it. With no gap, valid stays high into the next beat.
  task automatic send_request(req_t r);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd        <= r.cmd;
    op_type    <= r.op_type;
    line_state <= r.line_state;
    shared_in  <= r.shared_in;
    arg_state  <= r.arg_state;
    victim_tag <= r.victim_tag;
    req_valid  <= 1'b1;
    do @(posedge clk); while (!req_beat);
  endtask

  // Drop valid, let the monitor note the last request, wait for every
  // expected response, then let the two pipeline stages settle before
  // anything touches the configuration.
  task automatic drain_responses();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_decisions.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Sample both channels at the edge, using the values that stood before it.
  always @(posedge clk) begin : beat_monitor
    req_t seen;
    rsp_t got;
    if (!rst) begin
      if (req_beat) begin
        seen.cmd        = cmd_t'(cmd);
        seen.op_type    = op_t'(op_type);
        seen.line_state = mstate_t'(line_state);
        seen.shared_in  = shared_in;
        seen.arg_state  = mstate_t'(arg_state);
        seen.victim_tag = victim_tag;
        sb.note_request(seen);
      end
      if (rsp_beat) begin
        got.new_state       = mstate_t'(new_state);
        got.state_write     = state_write;
        got.route           = route_t'(route);
        got.evict_to_lower  = evict_to_lower;
        got.evict_to_upper  = evict_to_upper;
        got.update_to_upper = update_to_upper;
        got.update_to_lower = update_to_lower;
        got.shared_out      = shared_out;
        got.data_out        = data_out;
        got.message_tag     = message_tag;
        got.error           = error;
        sb.check_response(got);
      end
    end
  end

  // Response side: stall for a random number of cycles per beat, then take
  // the next beat whenever it shows up.
  initial begin : response_sink
    int n;
    wait (!rst);
    @(posedge clk);
    forever begin
      n = draw_gap();
      if (n > 0) begin
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
        rsp_stall <= 1'b0;
      end
      do @(posedge clk); while (!rsp_beat);
    end
  end

  // Main sequence: reset, directed corner cases, then random phases that
  // walk through every setting of the two configuration bits.
  initial begin : stimulus
    req_t             r;
    logic [1:0]       plan [4];
    logic [1:0]       setting;
    logic [63:0]      wide;
    int               kind;
    plan = '{2'b00, 2'b11, 2'b01, 2'b10};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Lowest private level: fill errors, shared-fill write cases, snoop
    // response flags, the unused event code and insert messages.
    apply_setting(1'b0, 1'b1);
    send_request(pack_request(CMD_FILL, OP_UPDATE, ST_S, 1'b0, ST_I, '0));
    send_request(pack_request(CMD_FILL, OP_WRITE, ST_S, 1'b1, ST_I, '0));
    send_request(pack_request(CMD_FILL, OP_WRITE, ST_E, 1'b1, ST_I, '0));
    send_request(pack_request(CMD_FILL, OP_WRITE, ST_I, 1'b1, ST_M, '1));
    send_request(pack_request(CMD_FILL, OP_READ, ST_M, 1'b1, ST_I, '0));
    send_request(pack_request(CMD_FILL, OP_EVICT, ST_M, 1'b0, ST_E, '0));
    send_request(pack_request(CMD_SNOOP_HIT, OP_READ, ST_I, 1'b0, ST_I, '0));
    send_request(pack_request(CMD_SNOOP_HIT, OP_WRITE, ST_M, 1'b0, ST_I, '0));
    send_request(pack_request(CMD_SNOOP_HIT, OP_READ, ST_E, 1'b1, ST_S, '0));
    send_request(pack_request(CMD_UNUSED, OP_EVICT, ST_M, 1'b1, ST_M, '1));
    send_request(pack_request(CMD_INSERT, OP_READ, ST_M, 1'b0, ST_I, '1));
    send_request(pack_request(CMD_INSERT, OP_WRITE, ST_E, 1'b0, ST_I, '0));
    send_request(pack_request(CMD_LOCAL_HIT, OP_WRITE, ST_S, 1'b0, ST_I, '0));
    send_request(pack_request(CMD_FLUSH, OP_READ, ST_M, 1'b0, ST_I, '1));
    send_request(pack_request(CMD_LOCAL_MISS, OP_WRITE, ST_I, 1'b0, ST_I, '0));
    send_request(pack_request(CMD_SNOOP_MISS, OP_UPDATE, ST_S, 1'b0, ST_I, '0));
    drain_responses();

    // Private but not lowest: fills take the carried state.
    apply_setting(1'b1, 1'b0);
    send_request(pack_request(CMD_FILL, OP_READ, ST_I, 1'b0, ST_M, '0));
    send_request(pack_request(CMD_FILL, OP_EVICT, ST_S, 1'b1, ST_S, '0));
    send_request(pack_request(CMD_SNOOP_HIT, OP_UPDATE, ST_S, 1'b0, ST_E, '0));
    send_request(pack_request(CMD_LOCAL_HIT, OP_WRITE, ST_E, 1'b0, ST_I, '0));
    send_request(pack_request(CMD_INSERT, OP_EVICT, ST_M, 1'b0, ST_I, {(TAG_W/2){2'b10}}));
    drain_responses();

    // Shared level: fills land in E, inserts of clean lines send nothing.
    apply_setting(1'b0, 1'b0);
    send_request(pack_request(CMD_FILL, OP_WRITE, ST_I, 1'b1, ST_S, '0));
    send_request(pack_request(CMD_INSERT, OP_READ, ST_S, 1'b0, ST_I, '1));
    drain_responses();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      setting = (p < 4) ? plan[p] : 2'($urandom);
      apply_setting(setting[1], setting[0]);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Redraw the idling mode now and then to get zero-gap stretches.
        if (i % 50 == 0) steady = ($urandom_range(0, 3) == 0);
        r.cmd        = ($urandom_range(0, 15) == 0) ? CMD_UNUSED : cmd_t'($urandom_range(0, 6));
        r.op_type    = op_t'($urandom_range(0, 3));
        r.line_state = mstate_t'($urandom_range(0, 3));
        r.shared_in  = 1'($urandom_range(0, 1));
        r.arg_state  = mstate_t'($urandom_range(0, 3));
        kind = $urandom_range(0, 7);
        wide = {$urandom, $urandom};
        case (kind)
          0: r.victim_tag = '1;
          1: r.victim_tag = '0;
          2: r.victim_tag = TAG_W'(1) << $urandom_range(0, TAG_W - 1);
          default: r.victim_tag = wide[TAG_W-1:0];
        endcase
        send_request(r);
      end
      drain_responses();
    end

    $display("Covered %0d response beats across %0d configuration settings,",
             sb.checked, settings_seen);
    $display("with corner cases first and random gaps and stalls on both channels.");
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #5000000;
    $display("Timeout: %0d expected responses still outstanding", sb.pending_decisions.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
